// File: sv/inu_pkg.sv
// Shared types and constants for the integer nearest-neighbor upscaler.
package inu_pkg;

   localparam int PIXEL_W    = 24;
   localparam int SCALE_W    = 7;
   localparam int WIDTH_W    = 11;
   localparam int HEIGHT_W   = 16;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam int RSP_USER_W = 4;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_SCALE     = 2'd0,
      REG_IN_WIDTH  = 2'd1,
      REG_IN_HEIGHT = 2'd2
   } inu_reg_type;

   typedef enum logic {
      CMD_PUSH = 1'b0,
      CMD_PULL = 1'b1
   } inu_cmd_type;

   typedef enum logic [2:0] {
      ST_PUSHED  = 3'd0,
      ST_PIXEL   = 3'd1,
      ST_PAD     = 3'd2,
      ST_REFUSED = 3'd3,
      ST_EMPTY   = 3'd4
   } inu_status_type;

   typedef struct packed {
      logic           image_end;
      logic           row_end;
      inu_status_type status;
   } inu_meta_type;

endpackage

// File: sv/inu_line_buf.sv
// One-row line buffer: single write port, registered read port.
module inu_line_buf #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [ADDR_W-1:0]             wr_addr,
   input  logic [inu_pkg::PIXEL_W-1:0]   wr_data,
   input  logic                          rd_en,
   input  logic [ADDR_W-1:0]             rd_addr,
   output logic [inu_pkg::PIXEL_W-1:0]   rd_data
);
   import inu_pkg::*;

   logic [PIXEL_W-1:0] mem [DEPTH];
   logic [PIXEL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // hold the last read word until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/integer_nearest_upscaler.sv
// Integer nearest-neighbor upscaler: line buffer, replication counters, output register.
// Request beats pass through stage 1, then the output register; a stalled result channel
// holds them. Throughput: one request beat per cycle otherwise; one buffer write or read per beat.
// Reset (synchronous, active high) clears counters, pipeline valids and sets all
// registers to 1; the line buffer is not cleared, and it is only read after being written.
module integer_nearest_upscaler #(
   parameter int MAX_IN_WIDTH = 1024,
   parameter int MAX_SCALE    = 100
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [inu_pkg::PIXEL_W-1:0]       req_tdata,   // red[7:0], green[15:8], blue[23:16]
   input  logic [0:0]                        req_tuser,   // command[0]
   // result channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [inu_pkg::PIXEL_W-1:0]       rsp_tdata,   // out_red[7:0], out_green[15:8], out_blue[23:16]
   output logic [inu_pkg::RSP_USER_W-1:0]    rsp_tuser,   // status[2:0], image_end[3]
   output logic                              rsp_tlast,   // row_end
   // register write port
   input  logic                              csr_we,
   input  logic [inu_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [inu_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import inu_pkg::*;

   // Column counters must hold the effective width itself (the padding phase
   // parks source_column at w); keep at least two bits for the pad math.
   localparam int COL_RAW = $clog2(MAX_IN_WIDTH + 1);
   localparam int COL_W   = (COL_RAW < 2) ? 2 : COL_RAW;
   localparam int ADDR_W  = (MAX_IN_WIDTH > 1) ? $clog2(MAX_IN_WIDTH) : 1;
   localparam int SCL_RAW = $clog2(MAX_SCALE + 1);
   localparam int SCL_W   = (SCL_RAW < 2) ? 2 : SCL_RAW;

   // Effective (clamped) register values, computed at write time.
   logic [SCL_W-1:0]    eff_s_ff, eff_s_in;
   logic [COL_W-1:0]    eff_w_ff, eff_w_in;
   logic [HEIGHT_W-1:0] eff_h_ff, eff_h_in;
   logic                restart;

   // Stream state.
   logic                emit_ff, emit_in;
   logic [COL_W-1:0]    fill_ff, fill_in;
   logic [COL_W-1:0]    src_ff, src_in;
   logic [SCL_W-1:0]    hrep_ff, hrep_in;
   logic [SCL_W-1:0]    vrep_ff, vrep_in;
   logic [1:0]          pad_ff, pad_in;
   logic [HEIGHT_W-1:0] rows_ff, rows_in;

   // Pipeline: stage 1 waits on the buffer read, then the output register.
   logic                s1_valid_ff, s1_valid_in;
   inu_meta_type        s1_meta_ff, s1_meta_in;
   logic                rsp_valid_ff, rsp_valid_in;
   inu_meta_type        rsp_meta_ff;
   logic [PIXEL_W-1:0]  rsp_data_ff;

   logic                accept;
   logic                out_free;
   logic                s1_move;
   inu_cmd_type         cmd;
   logic [1:0]          pad_count;
   logic [1:0]          ws_low;
   logic                buf_wr;
   logic                buf_rd;
   logic [PIXEL_W-1:0]  buf_q;

   logic [COL_W:0]      fill_inc;
   logic [COL_W:0]      src_inc;
   logic [SCL_W:0]      hrep_inc;
   logic [SCL_W:0]      vrep_inc;
   logic [2:0]          pad_inc;
   logic [HEIGHT_W-1:0] rows_inc;

   // ---------------------------------------------------------------- handshake
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_move    = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign accept     = req_tvalid && req_tready;
   assign cmd        = inu_cmd_type'(req_tuser[0]);

   // ---------------------------------------------------------------- registers
   // Clamp on write so a beat right after a write already sees the new value.
   always_comb begin
      eff_s_in = eff_s_ff;
      eff_w_in = eff_w_ff;
      eff_h_in = eff_h_ff;
      restart  = 1'b0;
      if (csr_we) begin
         unique case (csr_addr)
            REG_SCALE: begin
               restart = 1'b1;
               if (csr_wdata[SCALE_W-1:0] == '0) begin
                  eff_s_in = SCL_W'(1);
               end else if (32'(csr_wdata[SCALE_W-1:0]) > 32'(MAX_SCALE)) begin
                  eff_s_in = SCL_W'(MAX_SCALE);
               end else begin
                  eff_s_in = SCL_W'(csr_wdata[SCALE_W-1:0]);
               end
            end
            REG_IN_WIDTH: begin
               restart = 1'b1;
               if (csr_wdata[WIDTH_W-1:0] == '0) begin
                  eff_w_in = COL_W'(1);
               end else if (32'(csr_wdata[WIDTH_W-1:0]) > 32'(MAX_IN_WIDTH)) begin
                  eff_w_in = COL_W'(MAX_IN_WIDTH);
               end else begin
                  eff_w_in = COL_W'(csr_wdata[WIDTH_W-1:0]);
               end
            end
            REG_IN_HEIGHT: begin
               restart  = 1'b1;
               eff_h_in = (csr_wdata == '0) ? HEIGHT_W'(1) : csr_wdata;
            end
            default: begin
               // unmapped index: drop the write, keep the stream going
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eff_s_ff <= SCL_W'(1);
         eff_w_ff <= COL_W'(1);
         eff_h_ff <= HEIGHT_W'(1);
      end else begin
         eff_s_ff <= eff_s_in;
         eff_w_ff <= eff_w_in;
         eff_h_ff <= eff_h_in;
      end
   end

   // Padding bytes per output row: enough to round 3*w*s bytes up to a multiple of four.
   // Only the low two bits of w and s matter.
   assign ws_low    = 2'(eff_w_ff[1:0] * eff_s_ff[1:0]);
   assign pad_count = 2'(2'd0 - 2'(ws_low * 2'd3));

   // ---------------------------------------------------------------- stream control
   assign fill_inc = {1'b0, fill_ff} + 1'b1;
   assign src_inc  = {1'b0, src_ff} + 1'b1;
   assign hrep_inc = {1'b0, hrep_ff} + 1'b1;
   assign vrep_inc = {1'b0, vrep_ff} + 1'b1;
   assign pad_inc  = {1'b0, pad_ff} + 1'b1;
   assign rows_inc = rows_ff + 1'b1;

   always_comb begin
      logic row_done;
      logic src_adv;
      row_done   = 1'b0;
      src_adv    = 1'b0;
      emit_in    = emit_ff;
      fill_in    = fill_ff;
      src_in     = src_ff;
      hrep_in    = hrep_ff;
      vrep_in    = vrep_ff;
      pad_in     = pad_ff;
      rows_in    = rows_ff;
      buf_wr     = 1'b0;
      buf_rd     = 1'b0;
      s1_meta_in = s1_meta_ff;

      if (accept) begin
         s1_meta_in.row_end   = 1'b0;
         s1_meta_in.image_end = 1'b0;
         unique case (cmd)
            CMD_PUSH: begin
               if (emit_ff) begin
                  s1_meta_in.status = ST_REFUSED;
               end else begin
                  s1_meta_in.status = ST_PUSHED;
                  buf_wr            = 1'b1;
                  if (fill_inc >= {1'b0, eff_w_ff}) begin
                     // row complete: start emitting it
                     fill_in = '0;
                     emit_in = 1'b1;
                     src_in  = '0;
                     hrep_in = '0;
                     vrep_in = '0;
                     pad_in  = '0;
                  end else begin
                     fill_in = fill_inc[COL_W-1:0];
                  end
               end
            end
            CMD_PULL: begin
               if (!emit_ff) begin
                  s1_meta_in.status = ST_EMPTY;
               end else begin
                  if (src_ff < eff_w_ff) begin
                     s1_meta_in.status = ST_PIXEL;
                     buf_rd            = 1'b1;
                     if (hrep_inc >= {1'b0, eff_s_ff}) begin
                        hrep_in = '0;
                        src_in  = src_inc[COL_W-1:0];
                        src_adv = 1'b1;
                     end else begin
                        hrep_in = hrep_inc[SCL_W-1:0];
                     end
                     row_done = src_adv && (src_inc >= {1'b0, eff_w_ff}) &&
                                (pad_count == 2'd0);
                  end else begin
                     s1_meta_in.status = ST_PAD;
                     pad_in            = pad_inc[1:0];
                     row_done          = (pad_inc >= {1'b0, pad_count});
                  end

                  if (row_done) begin
                     s1_meta_in.row_end = 1'b1;
                     src_in  = '0;
                     hrep_in = '0;
                     pad_in  = '0;
                     if (vrep_inc >= {1'b0, eff_s_ff}) begin
                        // last copy of this source row: back to filling
                        vrep_in = '0;
                        emit_in = 1'b0;
                        if (rows_inc >= eff_h_ff || rows_inc == '0) begin
                           s1_meta_in.image_end = 1'b1;
                           rows_in = '0;
                        end else begin
                           rows_in = rows_inc;
                        end
                     end else begin
                        vrep_in = vrep_inc[SCL_W-1:0];
                     end
                  end
               end
            end
            default: begin
               s1_meta_in.status = ST_EMPTY;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         emit_ff <= 1'b0;
         fill_ff <= '0;
         src_ff  <= '0;
         hrep_ff <= '0;
         vrep_ff <= '0;
         pad_ff  <= '0;
         rows_ff <= '0;
      end else begin
         emit_ff <= emit_in;
         fill_ff <= fill_in;
         src_ff  <= src_in;
         hrep_ff <= hrep_in;
         vrep_ff <= vrep_in;
         pad_ff  <= pad_in;
         rows_ff <= rows_in;
      end
   end

   // ---------------------------------------------------------------- line buffer
   // A pull only reads while emitting, and emitting is set by the same edge that
   // stores the last write of the row, so reads never race a write to the same slot.
   inu_line_buf #(
      .DEPTH  (MAX_IN_WIDTH),
      .ADDR_W (ADDR_W)
   ) u_line_buf (
      .clock   (clock),
      .wr_en   (buf_wr),
      .wr_addr (fill_ff[ADDR_W-1:0]),
      .wr_data (req_tdata),
      .rd_en   (buf_rd),
      .rd_addr (src_ff[ADDR_W-1:0]),
      .rd_data (buf_q)
   );

   // ---------------------------------------------------------------- pipeline
   // Stage 1 advances whenever the output register is empty or being drained;
   // the buffer read word holds while stage 1 is stalled since no read is issued.
   always_comb begin
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_meta_ff <= s1_meta_in;
      if (s1_move) begin
         rsp_meta_ff <= s1_meta_ff;
         // color is zero for every beat that carries no pixel
         rsp_data_ff <= (s1_meta_ff.status == ST_PIXEL) ? buf_q : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = {rsp_meta_ff.image_end, rsp_meta_ff.status};
   assign rsp_tlast  = rsp_meta_ff.row_end;

endmodule

// File: sv/inu_checker.sv
// Port-level checks for the upscaler result channel, bound to the top level.
module inu_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [inu_pkg::PIXEL_W-1:0]    rsp_tdata,
   input logic [inu_pkg::RSP_USER_W-1:0] rsp_tuser,
   input logic                           rsp_tlast
);
   import inu_pkg::*;

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
                                    $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result beat changed while stalled");

   // color only travels with a pixel beat
   a_color_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2:0] != ST_PIXEL |-> rsp_tdata == '0)
      else $error("nonzero color on a non-pixel beat");

   // the image ends on the last beat of a row
   a_image_row: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[3] |-> rsp_tlast)
      else $error("image end without row end");

   // only pulled elements close a row
   a_row_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser[2:0] == ST_PIXEL || rsp_tuser[2:0] == ST_PAD)
      else $error("row end on a beat that is neither pixel nor padding");

endmodule

bind integer_nearest_upscaler inu_checker u_inu_checker (.*);

// File: bench/integer_nearest_upscaler_test.sv
// Self-checking testbench for integer_nearest_upscaler: directed and random pixel streams.
`timescale 1ns / 1ps

module integer_nearest_upscaler_test;
   import inu_pkg::*;

   localparam int MAX_IN_WIDTH = 1024;
   localparam int MAX_SCALE    = 100;
   localparam int LB_ADDR_W    = $clog2(MAX_IN_WIDTH);
   // Index with no register behind it; a write there must leave the stream alone.
   localparam logic [CSR_ADDR_W-1:0] REG_UNUSED = 2'd3;

   // Pixel as it sits on the bus: red in the lowest byte.
   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } rgb_pixel_type;

   typedef struct packed {
      inu_cmd_type   cmd;
      rgb_pixel_type pixel;
   } upscale_req_type;

   typedef struct packed {
      logic           image_end;
      logic           row_end;
      inu_status_type status;
      rgb_pixel_type  pixel;
   } upscaled_beat_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [PIXEL_W-1:0]    req_tdata;
   logic [0:0]            req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [PIXEL_W-1:0]    rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   integer_nearest_upscaler #(
      .MAX_IN_WIDTH (MAX_IN_WIDTH),
      .MAX_SCALE    (MAX_SCALE)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // ---------------------------------------------------------------------
   // Predictor state: register copies and the upscaler's own counters.
   // ---------------------------------------------------------------------
   logic [SCALE_W-1:0]  cfg_scale    = 7'd1;
   logic [WIDTH_W-1:0]  cfg_width    = 11'd1;
   logic [HEIGHT_W-1:0] cfg_height   = 16'd1;
   rgb_pixel_type       line_buf [MAX_IN_WIDTH];
   logic [10:0]         fill_col     = '0;
   logic                emitting_row = 1'b0;
   logic [10:0]         src_col      = '0;
   logic [6:0]          h_rep        = '0;
   logic [6:0]          v_rep        = '0;
   logic [1:0]          pad_sent     = '0;
   logic [15:0]         rows_done    = '0;

   // Stimulus and scoreboard storage.
   upscale_req_type   pending_requests [$];
   upscaled_beat_type expected_beats [$];
   upscale_req_type   offer;
   upscaled_beat_type got;
   upscaled_beat_type want;
   int                requests_queued = 0;
   int                requests_taken  = 0;
   int                error_count     = 0;
   logic              req_fire;

   // Handshake pacing knobs, set per phase by the sequencer.
   int                send_idle_pct  = 0;
   int                recv_stall_pct = 0;
   // Cycles left in a long receiver hold-off; the receiver counts it down.
   int                rsp_hold_left  = 0;

   // Advance the predicted upscaler by one request beat and return its result beat.
   function automatic upscaled_beat_type upscale_next(input inu_cmd_type   cmd,
                                                      input rgb_pixel_type px);
      upscaled_beat_type res;
      int                w;
      int                s;
      int                h;
      int                pad_bytes;
      logic              row_done;
      // Clamp the registers the way the block does.
      w = (cfg_width == 0) ? 1 : (cfg_width > MAX_IN_WIDTH) ? MAX_IN_WIDTH : int'(cfg_width);
      s = (cfg_scale == 0) ? 1 : (cfg_scale > MAX_SCALE) ? MAX_SCALE : int'(cfg_scale);
      h = (cfg_height == 0) ? 1 : int'(cfg_height);
      pad_bytes = (4 - ((w * s * 3) & 3)) & 3;
      res = '0;
      res.status = ST_PUSHED;
      row_done = 1'b0;
      if (cmd == CMD_PUSH) begin
         if (emitting_row) begin
            // Row still going out: refuse and change nothing.
            res.status = ST_REFUSED;
         end else begin
            line_buf[fill_col[LB_ADDR_W-1:0]] = px;
            fill_col = fill_col + 11'd1;
            if (fill_col >= w) begin
               fill_col     = '0;
               emitting_row = 1'b1;
               src_col      = '0;
               h_rep        = '0;
               v_rep        = '0;
               pad_sent     = '0;
            end
         end
      end else if (!emitting_row) begin
         res.status = ST_EMPTY;
      end else if (src_col < w) begin
         res.status = ST_PIXEL;
         res.pixel  = line_buf[src_col[LB_ADDR_W-1:0]];
         h_rep = h_rep + 7'd1;
         if (h_rep >= s) begin
            h_rep   = '0;
            src_col = src_col + 11'd1;
         end
         if (src_col >= w && pad_bytes == 0) row_done = 1'b1;
      end else begin
         res.status = ST_PAD;
         pad_sent = pad_sent + 2'd1;
         if (pad_sent >= pad_bytes) row_done = 1'b1;
      end
      if (row_done) begin
         res.row_end = 1'b1;
         src_col  = '0;
         h_rep    = '0;
         pad_sent = '0;
         v_rep    = v_rep + 7'd1;
         if (v_rep >= s) begin
            // Whole row replicated vertically: back to filling.
            v_rep        = '0;
            emitting_row = 1'b0;
            rows_done    = rows_done + 16'd1;
            if (rows_done >= h || rows_done == 0) begin
               res.image_end = 1'b1;
               rows_done     = '0;
            end
         end
      end
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Clock and time limit.
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Bound the run far beyond the slowest legal schedule.
   initial begin
      #5000000;
      $display("integer_nearest_upscaler regression: fail");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Request driver: present the next pending beat at the falling edge,
   // hold it until the rising edge that takes it.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            offer = pending_requests.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= offer.cmd;
            req_tdata  <= offer.pixel;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result receiver: stall at random, or hold off entirely while a hold-off
   // count is running down.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_hold_left != 0) begin
         rsp_tready    <= 1'b0;
         rsp_hold_left <= rsp_hold_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: predict on every accepted request beat, check every result beat
   // against the oldest prediction.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            expected_beats.push_back(upscale_next(inu_cmd_type'(req_tuser[0]), req_tdata));
            requests_taken++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.pixel     = rsp_tdata;
            got.status    = inu_status_type'(rsp_tuser[2:0]);
            got.image_end = rsp_tuser[3];
            got.row_end   = rsp_tlast;
            if (expected_beats.size() == 0) begin
               if (error_count < 10)
                  $display("unexpected result beat: status %0d rgb %h row_end %b image_end %b",
                           got.status, got.pixel, got.row_end, got.image_end);
               error_count++;
            end else begin
               want = expected_beats.pop_front();
               if (got.status !== want.status || got.pixel !== want.pixel ||
                   got.row_end !== want.row_end || got.image_end !== want.image_end) begin
                  if (error_count < 10)
                     $display({"result mismatch: expected status %0d rgb %h row_end %b ",
                               "image_end %b, got status %0d rgb %h row_end %b image_end %b"},
                              want.status, want.pixel, want.row_end, want.image_end,
                              got.status, got.pixel, got.row_end, got.image_end);
                  error_count++;
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sequencer helpers.
   // ---------------------------------------------------------------------
   task automatic queue_req(input inu_cmd_type cmd, input logic [PIXEL_W-1:0] px);
      upscale_req_type item;
      item.cmd   = cmd;
      item.pixel = px;
      pending_requests.push_back(item);
      requests_queued++;
   endtask

   // Hold until every queued beat is taken and every result has come back,
   // then let the pipeline settle.
   task automatic wait_until_idle();
      while (requests_taken != requests_queued || expected_beats.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Write one register while idle and mirror it into the predictor.
   task automatic write_csr(input logic [CSR_ADDR_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (index)
         REG_SCALE:     cfg_scale  = value[SCALE_W-1:0];
         REG_IN_WIDTH:  cfg_width  = value[WIDTH_W-1:0];
         REG_IN_HEIGHT: cfg_height = value[HEIGHT_W-1:0];
         default:       return;
      endcase
      // Any real register write restarts the stream; the line buffer survives.
      fill_col     = '0;
      emitting_row = 1'b0;
      src_col      = '0;
      h_rep        = '0;
      v_rep        = '0;
      pad_sent     = '0;
      rows_done    = '0;
      @(negedge clock);
   endtask

   // Queue a well-formed image: per row, w pushes then every pull of the
   // enlarged row. Noise adds pulls while filling and pushes while emitting.
   // With cut set, stop somewhere inside the first row.
   task automatic queue_image(input int w, input int s, input int h, input int noise_pct,
                              input bit cut);
      int row_beats;
      int queued;
      int stop_at;
      int r;
      int c;
      int p;
      row_beats = s * (w * s + ((4 - ((w * s * 3) & 3)) & 3));
      stop_at   = cut ? $urandom_range(1, w + row_beats - 1) : 0;
      queued    = 0;
      for (r = 0; r < h; r++) begin
         for (c = 0; c < w; c++) begin
            if ($urandom_range(99) < noise_pct) queue_req(CMD_PULL, PIXEL_W'($urandom));
            queue_req(CMD_PUSH, PIXEL_W'($urandom));
            queued++;
            if (stop_at != 0 && queued >= stop_at) return;
         end
         for (p = 0; p < row_beats; p++) begin
            if ($urandom_range(99) < noise_pct) queue_req(CMD_PUSH, PIXEL_W'($urandom));
            queue_req(CMD_PULL, PIXEL_W'($urandom));
            queued++;
            if (stop_at != 0 && queued >= stop_at) return;
         end
      end
      if ($urandom_range(99) < noise_pct) queue_req(CMD_PULL, PIXEL_W'($urandom));
   endtask

   // ---------------------------------------------------------------------
   // Main sequence.
   // ---------------------------------------------------------------------
   initial begin
      int phase;
      int phase_goal;
      int s;
      int w;
      int h;
      int i;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      rsp_tready = 1'b0;
      csr_we     = 1'b0;
      csr_addr   = '0;
      csr_wdata  = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: reset registers give a one-pixel image with one pad byte.
      queue_req(CMD_PULL, 24'h000000);   // nothing ready while filling
      queue_req(CMD_PUSH, 24'h000000);
      queue_req(CMD_PUSH, 24'hFFFFFF);   // refused, row is going out
      queue_req(CMD_PULL, 24'hFFFFFF);
      queue_req(CMD_PULL, 24'h000000);   // pad byte closes row and image
      queue_req(CMD_PULL, 24'hFFFFFF);   // image done, nothing ready
      wait_until_idle();

      // Zero registers are taken as one.
      write_csr(REG_SCALE, 16'd0);
      write_csr(REG_IN_WIDTH, 16'd0);
      write_csr(REG_IN_HEIGHT, 16'd0);
      queue_req(CMD_PUSH, 24'hFFFFFF);
      queue_req(CMD_PULL, 24'h000000);
      queue_req(CMD_PULL, 24'h000000);
      wait_until_idle();

      // Scale two (upper data bits dropped), width two; a write to the unused
      // index in mid-row must not restart the stream.
      write_csr(REG_SCALE, 16'hFF82);
      write_csr(REG_IN_WIDTH, 16'd2);
      write_csr(REG_IN_HEIGHT, 16'd1);
      queue_req(CMD_PUSH, 24'hA5A5A5);
      queue_req(CMD_PUSH, 24'h5A5A5A);
      repeat (3) queue_req(CMD_PULL, 24'h000000);
      wait_until_idle();
      write_csr(REG_UNUSED, 16'hFFFF);
      repeat (5) queue_req(CMD_PULL, 24'hFFFFFF);
      wait_until_idle();

      // Extremes: scale above the top is clamped; one pixel blown up 100 times,
      // the first output row closes on the hundredth pull. Stop inside the
      // second copy; the next register write restarts the stream.
      write_csr(REG_SCALE, 16'd127);
      write_csr(REG_IN_WIDTH, 16'd1);
      write_csr(REG_IN_HEIGHT, 16'd1);
      queue_req(CMD_PUSH, 24'h3C5A96);
      repeat (MAX_SCALE + 1) queue_req(CMD_PULL, 24'h000000);
      wait_until_idle();

      // Width above the top is clamped to a full line buffer: the row starts
      // going out right after the last slot is filled.
      write_csr(REG_SCALE, 16'd1);
      write_csr(REG_IN_WIDTH, 16'd2047);
      for (i = 0; i < MAX_IN_WIDTH - 1; i++) queue_req(CMD_PUSH, PIXEL_W'($urandom));
      queue_req(CMD_PULL, 24'h000000);   // one slot left, still filling
      queue_req(CMD_PUSH, PIXEL_W'($urandom));
      queue_req(CMD_PUSH, 24'h000000);   // refused, row is going out
      repeat (4) queue_req(CMD_PULL, 24'h000000);
      wait_until_idle();

      // Tallest image: run a few rows, the image never ends here.
      write_csr(REG_IN_WIDTH, 16'd3);
      write_csr(REG_IN_HEIGHT, 16'hFFFF);
      queue_image(3, 1, 6, 0, 1'b0);
      wait_until_idle();

      // Back-pressure: hold the receiver off while the sender keeps offering,
      // so the pipeline fills and req_tready drops; then wait out the hold-off
      // and wait until every result is back.
      write_csr(REG_SCALE, 16'd4);
      write_csr(REG_IN_WIDTH, 16'd8);
      write_csr(REG_IN_HEIGHT, 16'd1);
      queue_image(8, 4, 1, 0, 1'b0);
      @(posedge clock);
      rsp_hold_left = 200;
      wait (rsp_hold_left == 0);
      wait_until_idle();

      // Random images across the pacing phases.
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
            default: begin send_idle_pct = 32; recv_stall_pct = 32; end
         endcase
         phase_goal = requests_queued + 60;
         while (requests_queued < phase_goal) begin
            // Keep images small; only narrow ones get the larger scales.
            s = ($urandom_range(9) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
            if (s > 4)
               w = $urandom_range(1, 3);
            else if (s <= 2 && $urandom_range(9) == 0)
               w = $urandom_range(9, 40);
            else
               w = $urandom_range(1, 8);
            h = (s > 4 || w > 8) ? 1 : $urandom_range(1, 3);
            wait_until_idle();
            write_csr(REG_SCALE, CSR_DATA_W'(s));
            write_csr(REG_IN_WIDTH, CSR_DATA_W'(w));
            write_csr(REG_IN_HEIGHT, CSR_DATA_W'(h));
            // Now and then break off mid-row; the next register write restarts.
            queue_image(w, s, h, 5, $urandom_range(4) == 0);
         end
      end

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      wait_until_idle();
      repeat (6) @(negedge clock);
      if (error_count == 0 && expected_beats.size() == 0) begin
         $display("integer_nearest_upscaler regression: pass");
      end else begin
         $display("integer_nearest_upscaler regression: fail");
      end
      $finish;
   end

endmodule

// File: sim.f
sv/inu_pkg.sv
sv/inu_line_buf.sv
sv/integer_nearest_upscaler.sv
sv/inu_checker.sv
bench/integer_nearest_upscaler_test.sv
